// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== src/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Command queue between decoder and emitter; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_TRUNC_U = 3'd1,
        ERR_BAD_HEX = 3'd2,
        ERR_BAD_ESC = 3'd3,
        ERR_CTRL    = 3'd4
    } t_err;

    // Up to four UTF-8 bytes, first byte in bytes[0].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n_bytes;
    } t_utf8;

    // Everything one input byte produces: data bytes, then an optional status item.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n_bytes;
        logic            status;
        t_err            err;
    } t_cmd;

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u.bytes = '0;
        if (cp < 21'h80) begin
            u.bytes[0] = cp[7:0];
            u.n_bytes  = 3'd1;
        end else if (cp < 21'h800) begin
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
            u.n_bytes  = 3'd2;
        end else if (cp < 21'h10000) begin
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
            u.n_bytes  = 3'd3;
        end else begin
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
            u.n_bytes  = 3'd4;
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== src/json_string_unescape_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// JSON string body unescaper. Takes one escaped byte per transfer, with
// i_in_last on the final byte of a string, and gives the decoded bytes (UTF-8
// for \u escapes, surrogate pairs joined into 4-byte characters) followed by
// one status item per string carrying the error code. The decoder takes one
// input byte every cycle; the emitter gives one result item every cycle while a
// command waits and the output is not stalled. An input byte makes 0 to 5
// result items, usually 1. A 4-entry command queue between the two soaks up
// bursts such as a 4-byte \u escape; input stalls only when that queue is full.

`include "assert_macros.svh"

module json_string_unescape_decoder_unit import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_is_data,
    output logic [2:0]      o_error_code,
    output logic            o_out_last
);

    logic push, pop, q_full, q_valid;
    t_cmd push_cmd, head_cmd;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_q_full  (q_full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_error_code (o_error_code),
        .o_out_last   (o_out_last)
    );

    `ASSERT_NEVER(a_push_when_full, push && q_full, "command pushed into full queue")
    `ASSERT_NEVER(a_pop_when_empty, pop && !q_valid, "command popped from empty queue")
    `ASSERT_CLK(a_status_shape, o_valid |-> (o_is_data != o_out_last), "status/data mismatch")
    `ASSERT_CLK(a_data_no_err, (o_valid && o_is_data) |-> (o_error_code == ERR_NONE), "error on data")
    `ASSERT_CLK(a_push_has_items, push |-> (push_cmd.status || push_cmd.n_bytes != 3'd0), "empty command")

endmodule

`default_nettype wire

// ===== src/jsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_in_last,
    input  wire logic       i_q_full,
    output logic            o_ready,
    output logic            o_push,
    output t_cmd            o_cmd
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;
    localparam logic [15:0] HI_SURR_LO = 16'hD800;
    localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESC,
        M_HEX1,
        M_HEX2,
        M_HEX3,
        M_HEX4,
        M_DRAIN
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic        r_bad, n_bad;
    logic [15:0] r_pend, n_pend;
    logic        r_pv, n_pv;
    t_err        r_err, n_err;

    logic        accept;
    logic [3:0]  nib;
    logic        nib_ok;
    logic [7:0]  esc_byte;
    logic        esc_ok;
    logic [15:0] hex_shift;
    logic        flush_b, flush_a;
    logic        main_raw, main_cp;
    logic [20:0] cp;
    logic        fail_v;
    t_err        fail_code;
    t_utf8       main_u, pu_old, pu_new;
    t_cmd        cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        nib_ok = 1'b1;
        nib    = i_in_byte[3:0];
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            nib = i_in_byte[3:0];
        end else if ((i_in_byte >= 8'h61 && i_in_byte <= 8'h66) ||
                     (i_in_byte >= 8'h41 && i_in_byte <= 8'h46)) begin
            nib = i_in_byte[3:0] + 4'd9;
        end else begin
            nib_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = i_in_byte;
        case (i_in_byte)
            8'h22, 8'h27, 8'h5C, 8'h2F: esc_byte = i_in_byte;
            8'h6E: esc_byte = 8'h0A;
            8'h72: esc_byte = 8'h0D;
            8'h74: esc_byte = 8'h09;
            8'h62: esc_byte = 8'h08;
            8'h66: esc_byte = 8'h0C;
            default: esc_ok = 1'b0;
        endcase
    end

    assign hex_shift = {r_hex[11:0], nib_ok ? nib : 4'h0};
    assign pu_old    = utf8_encode({5'b0, r_pend});

    always_comb begin
        n_mode    = r_mode;
        n_hex     = r_hex;
        n_bad     = r_bad;
        n_pend    = r_pend;
        n_pv      = r_pv;
        n_err     = r_err;
        flush_b   = 1'b0;
        main_raw  = 1'b0;
        main_cp   = 1'b0;
        cp        = '0;
        fail_v    = 1'b0;
        fail_code = ERR_NONE;
        main_u    = '0;
        pu_new    = '0;
        flush_a   = 1'b0;
        cmd       = '0;

        case (r_mode)
            M_DRAIN: begin
            end
            M_ESC: begin
                if (i_in_byte == CH_U) begin
                    n_mode = M_HEX1;
                    n_hex  = '0;
                    n_bad  = 1'b0;
                    if (i_in_last) begin
                        fail_v    = 1'b1;
                        fail_code = ERR_TRUNC_U;
                    end
                end else if (!esc_ok) begin
                    fail_v    = 1'b1;
                    fail_code = ERR_BAD_ESC;
                end else begin
                    flush_b  = r_pv;
                    n_pv     = 1'b0;
                    main_raw = 1'b1;
                    n_mode   = M_NORMAL;
                end
            end
            M_HEX1, M_HEX2, M_HEX3, M_HEX4: begin
                // a held high surrogate goes out once the digits rule out a low one
                if (r_pv && r_mode == M_HEX1 && (!nib_ok || nib != 4'hD)) begin
                    flush_b = 1'b1;
                end
                if (r_pv && r_mode == M_HEX2 && (!nib_ok || nib < 4'hC)) begin
                    flush_b = 1'b1;
                end
                if (flush_b) begin
                    n_pv = 1'b0;
                end
                if (!nib_ok) begin
                    n_bad = 1'b1;
                end
                n_hex = hex_shift;
                if (r_mode != M_HEX4) begin
                    case (r_mode)
                        M_HEX1:  n_mode = M_HEX2;
                        M_HEX2:  n_mode = M_HEX3;
                        default: n_mode = M_HEX4;
                    endcase
                    if (i_in_last) begin
                        fail_v    = 1'b1;
                        fail_code = ERR_TRUNC_U;
                    end
                end else if (n_bad) begin
                    fail_v    = 1'b1;
                    fail_code = ERR_BAD_HEX;
                end else begin
                    if (r_pv) begin
                        cp      = {1'b0, r_pend[9:0], hex_shift[9:0]} + SUPP_BASE;
                        main_cp = 1'b1;
                        n_pv    = 1'b0;
                    end else if (hex_shift >= HI_SURR_LO && hex_shift <= HI_SURR_HI) begin
                        n_pend = hex_shift;
                        n_pv   = 1'b1;
                    end else begin
                        cp      = {5'b0, hex_shift};
                        main_cp = 1'b1;
                    end
                    n_mode = M_NORMAL;
                    n_hex  = '0;
                    n_bad  = 1'b0;
                end
            end
            default: begin
                if (i_in_byte == CH_BSLASH) begin
                    n_mode = M_ESC;
                    if (i_in_last) begin
                        fail_v    = 1'b1;
                        fail_code = ERR_BAD_ESC;
                    end
                end else if (i_in_byte <= CTRL_MAX) begin
                    fail_v    = 1'b1;
                    fail_code = ERR_CTRL;
                end else begin
                    flush_b  = r_pv;
                    n_pv     = 1'b0;
                    main_raw = 1'b1;
                end
            end
        endcase

        if (fail_v) begin
            n_err  = fail_code;
            n_pv   = 1'b0;
            n_pend = '0;
            n_mode = M_DRAIN;
        end

        if (main_raw) begin
            main_u.bytes[0] = (r_mode == M_ESC) ? esc_byte : i_in_byte;
            main_u.n_bytes  = 3'd1;
        end else if (main_cp) begin
            main_u = utf8_encode(cp);
        end

        flush_a = i_in_last && (n_mode != M_DRAIN) && n_pv;
        pu_new  = utf8_encode({5'b0, n_pend});

        if (flush_b) begin
            cmd.bytes[2:0] = pu_old.bytes[2:0];
            cmd.bytes[3]   = main_u.bytes[0];
            cmd.n_bytes    = 3'd3 + main_u.n_bytes;
        end else if (flush_a) begin
            cmd.bytes[2:0] = pu_new.bytes[2:0];
            cmd.n_bytes    = 3'd3;
        end else begin
            cmd.bytes   = main_u.bytes;
            cmd.n_bytes = main_u.n_bytes;
        end
        cmd.status = i_in_last;
        cmd.err    = (i_in_last && n_mode == M_DRAIN) ? n_err : ERR_NONE;

        // status item closes the string; all state goes back to reset values
        if (i_in_last) begin
            n_mode = M_NORMAL;
            n_hex  = '0;
            n_bad  = 1'b0;
            n_pend = '0;
            n_pv   = 1'b0;
            n_err  = ERR_NONE;
        end
    end

    assign o_push = accept && (cmd.status || cmd.n_bytes != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_hex  <= '0;
            r_bad  <= 1'b0;
            r_pend <= '0;
            r_pv   <= 1'b0;
            r_err  <= ERR_NONE;
        end else if (accept) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_bad  <= n_bad;
            r_pend <= n_pend;
            r_pv   <= n_pv;
            r_err  <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== src/jsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue import jsu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/jsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    input  wire logic       i_ready,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_is_data,
    output logic [2:0]      o_error_code,
    output logic            o_out_last
);

    logic       r_ov;
    logic [2:0] r_idx;
    logic [7:0] r_byte;
    logic       r_is_data;
    t_err       r_err;
    logic       r_last;

    logic       load;
    logic       data_item;
    logic [2:0] n_items;
    logic       end_item;

    assign n_items   = i_cmd.n_bytes + {2'b0, i_cmd.status};
    assign data_item = (r_idx < i_cmd.n_bytes);
    assign end_item  = (r_idx + 3'd1 == n_items);
    assign load      = i_q_valid && (!r_ov || i_ready);
    assign o_pop     = load && end_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= '0;
        end else if (load) begin
            r_ov  <= 1'b1;
            r_idx <= end_item ? 3'd0 : r_idx + 3'd1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= data_item ? i_cmd.bytes[r_idx[1:0]] : 8'h00;
            r_is_data <= data_item;
            r_err     <= data_item ? ERR_NONE : i_cmd.err;
            r_last    <= !data_item;
        end
    end

    assign o_valid      = r_ov;
    assign o_out_byte   = r_byte;
    assign o_is_data    = r_is_data;
    assign o_error_code = r_err;
    assign o_out_last   = r_last;

endmodule

`default_nettype wire
